// File: rtl/pedigree_inverse_relationship_macros.svh
`ifndef PEDIGREE_INVERSE_RELATIONSHIP_MACROS_SVH
`define PEDIGREE_INVERSE_RELATIONSHIP_MACROS_SVH

// same-cycle implication, checked while out of reset
`define PIR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pir assertion failed");

// next-cycle implication, checked while out of reset
`define PIR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pir assertion failed");

`endif

// File: rtl/pir_pkg.sv
package pir_pkg;

	localparam int FRAC_BITS   = 30;
	localparam int ID_W        = 16;
	localparam int MAX_ANIMALS = 65535;
	localparam int TABLE_DEPTH = 1 << ID_W;
	localparam int BIT_W       = 6;
	localparam int WORD_BITS   = 1 << BIT_W;
	localparam int PEND_IDX_W  = ID_W - BIT_W;
	localparam int PEND_WORDS  = 1 << PEND_IDX_W;
	localparam int VAL_W       = 32;
	localparam int F_W         = 34;
	localparam int DIAG_W      = 34;
	localparam int W_W         = 41;
	localparam int RECIP_STEPS = 2 * FRAC_BITS + 1;

	localparam logic [VAL_W-1:0] ONE_Q = VAL_W'(1) << FRAC_BITS;
	localparam logic [W_W-1:0]   W_CAP = W_W'(1) << (W_W - 1);

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_ORDER = 2'd1,
		ERR_VAR   = 2'd2,
		ERR_CAP   = 2'd3
	} err_t;

	typedef struct packed {
		logic [ID_W-1:0] sire;
		logic [ID_W-1:0] dam;
		logic            start;
		logic            has_sire;
		logic            has_dam;
	} cmd_t;

	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] den;
	} recip_req_t;

	typedef struct packed {
		logic           done;
		logic [W_W-1:0] w;
	} recip_rsp_t;

endpackage

// File: rtl/pir_front.sv
module pir_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [pir_pkg::ID_W-1:0]  sire_id,
	input  logic [pir_pkg::ID_W-1:0]  dam_id,
	input  logic                      start_pedigree,
	output logic                      cmd_valid,
	input  logic                      cmd_ready,
	output pir_pkg::cmd_t             cmd
);
	import pir_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;

	assign in_ready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// classify parents as known or unknown on the way in
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1.sire     <= sire_id;
			cmd_s1.dam      <= dam_id;
			cmd_s1.start    <= start_pedigree;
			cmd_s1.has_sire <= (sire_id != '0);
			cmd_s1.has_dam  <= (dam_id != '0);
		end
	end

endmodule

// File: rtl/pir_queue.sv
module pir_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  pir_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output pir_pkg::cmd_t pop_cmd
);
	import pir_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop) fill_q <= fill_q + 2'd1;
			else if (do_pop && !do_push) fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// File: rtl/pir_recip.sv
module pir_recip (
	input  logic                clk,
	input  logic                arst_n,
	input  pir_pkg::recip_req_t req,
	output pir_pkg::recip_rsp_t rsp
);
	import pir_pkg::*;

	localparam int CNT_W = $clog2(RECIP_STEPS);

	logic             busy_q;
	logic             done_q;
	logic             sat_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VAL_W-1:0] den_q;
	logic [VAL_W-1:0] rem_q;
	logic [W_W-2:0]   quo_q;
	logic [VAL_W-1:0] rem_sh;
	logic             ge;
	logic [W_W-1:0]   quo_nx;

	// one quotient bit a cycle, the dividend is one squared
	assign rem_sh = {rem_q[VAL_W-2:0], (cnt_q == '0)};
	assign ge     = (rem_sh >= den_q);
	assign quo_nx = {quo_q, ge};

	assign rsp.done = done_q;
	assign rsp.w    = sat_q ? W_CAP : {1'b0, quo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (quo_nx[W_W-1]) sat_q <= 1'b1;
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(RECIP_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - den_q) : rem_sh;
			quo_q <= quo_nx[W_W-2:0];
		end
	end

endmodule

// File: rtl/pir_back.sv
`include "pedigree_inverse_relationship_macros.svh"

module pir_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_ready,
	input  pir_pkg::cmd_t            cmd,
	output pir_pkg::recip_req_t      recip_req,
	input  pir_pkg::recip_rsp_t      recip_rsp,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [pir_pkg::ID_W-1:0] row_id,
	output logic [pir_pkg::ID_W-1:0] col_id,
	output logic [31:0]              contribution,
	output logic [31:0]              inbreeding,
	output pir_pkg::err_t            error_code,
	output logic                     last
);
	import pir_pkg::*;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_CHECK, ST_VAR, ST_WRD, ST_WGET, ST_WM1, ST_WM2,
		ST_SRD, ST_SWR, ST_DRD, ST_DWR, ST_CRD, ST_CWR, ST_SCRD, ST_SCHK,
		ST_FIN, ST_EMIT, ST_ERR
	} state_t;

	typedef enum logic [3:0] {
		K_DIAG, K_S1, K_S2, K_S3, K_D1, K_D2, K_D3, K_B1, K_B2, K_NONE
	} kind_t;

	state_t state_q;
	kind_t  kind_q;
	kind_t  kind_nx;

	logic [ID_W-1:0]       cnt_q, sire_q, dam_q, id_q, j_q, sj_q, dj_q;
	logic                  hs_q, hd_q, first_q;
	logic [VAL_W-1:0]      l_q, vj_q, m1_q, m2_q;
	logic [DIAG_W-1:0]     diag_q;
	logic [F_W-1:0]        fi_q;
	logic [PEND_IDX_W-1:0] scan_q, clr_q;
	err_t                  err_q;
	err_t                  err_out_q;

	logic [ID_W-1:0]       row_q, col_q;
	logic [31:0]           contr_q, inb_q;
	logic                  valid_q, last_q;

	// tables
	logic [ID_W-1:0]      sire_mem [TABLE_DEPTH];
	logic [ID_W-1:0]      dam_mem  [TABLE_DEPTH];
	logic [VAL_W-1:0]     var_mem  [TABLE_DEPTH];
	logic [F_W-1:0]       inb_mem  [TABLE_DEPTH];
	logic [VAL_W-1:0]     pw_mem   [TABLE_DEPTH];
	logic [WORD_BITS-1:0] pend_mem [PEND_WORDS];

	logic [ID_W-1:0]      sire_rd, dam_rd;
	logic [VAL_W-1:0]     var_rd, pw_rd;
	logic [F_W-1:0]       inb_rd_s, inb_rd_d;
	logic [WORD_BITS-1:0] pend_rd;

	logic                  out_free;
	logic                  emit_go;
	logic [ID_W-1:0]       id_nx;
	logic [ID_W-1:0]       pw_ra, par;
	logic [PEND_IDX_W-1:0] pend_ra, pend_wa;
	logic                  pend_we, pw_we, tab_we, inb_we;
	logic [WORD_BITS-1:0]  pend_wd, cw_word, cw_masked;
	logic [VAL_W-1:0]      pw_wd, pw_old;
	logic signed [F_W-1:0] fs, fd;
	logic signed [F_W+1:0] var_full;
	logic [2*VAL_W-1:0]    prod1, prod2;
	logic signed [F_W:0]   fi_full;
	logic [W_W-1:0]        w;
	logic signed [W_W:0]   w_pos, w_half_neg, w_quarter, val_sel;
	logic [ID_W-1:0]       row_sel, col_sel;

	function automatic logic [BIT_W-1:0] hi_bit(input logic [WORD_BITS-1:0] v);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (v[b]) r = BIT_W'(b);
		end
		return r;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [W_W:0] v);
		logic [31:0] r;
		if (v > $signed((W_W + 1)'(32'h7fff_ffff))) r = 32'h7fff_ffff;
		else if (v < -$signed((W_W + 1)'(33'h0_8000_0000))) r = 32'h8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	assign out_free  = !valid_q || out_ready;
	assign emit_go   = out_free && ((state_q == ST_EMIT) || (state_q == ST_ERR));
	assign cmd_ready = (state_q == ST_IDLE);
	assign id_nx     = cnt_q + ID_W'(1);

	// parent inbreeding, an unknown parent counts as minus one
	assign fs = (sire_q == '0) ? -$signed(F_W'(ONE_Q)) : $signed(inb_rd_s);
	assign fd = (dam_q == '0) ? -$signed(F_W'(ONE_Q)) : $signed(inb_rd_d);
	assign var_full = $signed((F_W + 2)'(ONE_Q >> 1))
		- ((($signed((F_W + 2)'(fs)) + $signed((F_W + 2)'(fd)))) >>> 2);

	assign prod1   = 64'(l_q) * 64'(l_q);
	assign prod2   = 64'(m1_q) * 64'(vj_q);
	assign fi_full = $signed({1'b0, diag_q}) - $signed((F_W + 1)'(ONE_Q));

	// path weight update for a parent
	assign par     = (state_q == ST_DWR) ? dj_q : sj_q;
	assign pw_old  = pend_rd[par[BIT_W-1:0]] ? pw_rd : '0;
	assign pw_wd   = pw_old + (l_q >> 1);
	assign pw_we   = (state_q == ST_SWR) || (state_q == ST_DWR);

	assign cw_word   = pend_rd & ~(WORD_BITS'(1) << j_q[BIT_W-1:0]);
	assign cw_masked = cw_word & ((WORD_BITS'(1) << j_q[BIT_W-1:0]) - WORD_BITS'(1));

	always_comb begin
		case (state_q)
			ST_SRD:  pw_ra = sj_q;
			ST_DRD:  pw_ra = dj_q;
			default: pw_ra = j_q;
		endcase
		case (state_q)
			ST_SRD:  pend_ra = sj_q[ID_W-1:BIT_W];
			ST_DRD:  pend_ra = dj_q[ID_W-1:BIT_W];
			ST_SCRD: pend_ra = scan_q;
			default: pend_ra = j_q[ID_W-1:BIT_W];
		endcase
		pend_we = 1'b0;
		pend_wa = j_q[ID_W-1:BIT_W];
		pend_wd = cw_word;
		case (state_q)
			ST_CLEAR: begin
				pend_we = 1'b1;
				pend_wa = clr_q;
				pend_wd = '0;
			end
			ST_SWR, ST_DWR: begin
				pend_we = 1'b1;
				pend_wa = par[ID_W-1:BIT_W];
				pend_wd = pend_rd | (WORD_BITS'(1) << par[BIT_W-1:0]);
			end
			ST_CWR: pend_we = 1'b1;
			default: ;
		endcase
	end

	assign tab_we = (state_q == ST_VAR) && (var_full > 0);
	assign inb_we = (state_q == ST_FIN);

	always_ff @(posedge clk) begin
		sire_rd  <= sire_mem[j_q];
		dam_rd   <= dam_mem[j_q];
		var_rd   <= var_mem[j_q];
		if (tab_we) begin
			sire_mem[id_q] <= sire_q;
			dam_mem[id_q]  <= dam_q;
			var_mem[id_q]  <= var_full[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		inb_rd_s <= inb_mem[sire_q];
		inb_rd_d <= inb_mem[dam_q];
		if (inb_we) inb_mem[id_q] <= fi_full[F_W-1:0];
	end

	always_ff @(posedge clk) begin
		pw_rd <= pw_mem[pw_ra];
		if (pw_we) pw_mem[par] <= pw_wd;
	end

	always_ff @(posedge clk) begin
		pend_rd <= pend_mem[pend_ra];
		if (pend_we) pend_mem[pend_wa] <= pend_wd;
	end

	// result sequence
	assign w          = recip_rsp.w;
	assign w_pos      = $signed({1'b0, w});
	assign w_half_neg = -$signed({2'b0, w[W_W-1:1]});
	assign w_quarter  = $signed({3'b0, w[W_W-1:2]});

	always_comb begin
		row_sel = id_q;
		col_sel = id_q;
		val_sel = w_pos;
		kind_nx = K_NONE;
		case (kind_q)
			K_DIAG: kind_nx = hs_q ? K_S1 : (hd_q ? K_D1 : K_NONE);
			K_S1: begin
				col_sel = sire_q; val_sel = w_half_neg; kind_nx = K_S2;
			end
			K_S2: begin
				row_sel = sire_q; val_sel = w_half_neg; kind_nx = K_S3;
			end
			K_S3: begin
				row_sel = sire_q; col_sel = sire_q; val_sel = w_quarter;
				kind_nx = hd_q ? K_D1 : K_NONE;
			end
			K_D1: begin
				col_sel = dam_q; val_sel = w_half_neg; kind_nx = K_D2;
			end
			K_D2: begin
				row_sel = dam_q; val_sel = w_half_neg; kind_nx = K_D3;
			end
			K_D3: begin
				row_sel = dam_q; col_sel = dam_q; val_sel = w_quarter;
				kind_nx = hs_q ? K_B1 : K_NONE;
			end
			K_B1: begin
				row_sel = sire_q; col_sel = dam_q; val_sel = w_quarter; kind_nx = K_B2;
			end
			K_B2: begin
				row_sel = dam_q; col_sel = sire_q; val_sel = w_quarter;
			end
			default: ;
		endcase
	end

	assign recip_req.start = tab_we;
	assign recip_req.den   = var_full[VAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			cnt_q     <= '0;
			valid_q   <= 1'b0;
			kind_q    <= K_NONE;
			err_out_q <= ERR_OK;
		end else begin
			if (emit_go) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + PEND_IDX_W'(1);
					if (clr_q == PEND_IDX_W'(PEND_WORDS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						sire_q <= cmd.sire;
						dam_q  <= cmd.dam;
						hs_q   <= cmd.has_sire;
						hd_q   <= cmd.has_dam;
						if (cmd.start) cnt_q <= '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					id_q <= id_nx;
					if (cnt_q >= ID_W'(MAX_ANIMALS)) begin
						err_q   <= ERR_CAP;
						state_q <= ST_ERR;
					end else if (sire_q >= id_nx || dam_q >= id_nx) begin
						err_q   <= ERR_ORDER;
						state_q <= ST_ERR;
					end else begin
						state_q <= ST_VAR;
					end
				end
				ST_VAR: begin
					if (var_full <= 0) begin
						err_q   <= ERR_VAR;
						state_q <= ST_ERR;
					end else begin
						err_q   <= ERR_OK;
						cnt_q   <= id_q;
						j_q     <= id_q;
						first_q <= 1'b1;
						diag_q  <= '0;
						state_q <= ST_WRD;
					end
				end
				ST_WRD: state_q <= ST_WGET;
				ST_WGET: begin
					l_q     <= first_q ? ONE_Q : pw_rd;
					first_q <= 1'b0;
					sj_q    <= sire_rd;
					dj_q    <= dam_rd;
					vj_q    <= var_rd;
					state_q <= ST_WM1;
				end
				ST_WM1: begin
					m1_q    <= prod1[FRAC_BITS +: VAL_W];
					state_q <= ST_WM2;
				end
				ST_WM2: begin
					m2_q <= prod2[FRAC_BITS +: VAL_W];
					if (sj_q != '0) state_q <= ST_SRD;
					else if (dj_q != '0) state_q <= ST_DRD;
					else state_q <= ST_CRD;
				end
				ST_SRD: state_q <= ST_SWR;
				ST_SWR: state_q <= (dj_q != '0) ? ST_DRD : ST_CRD;
				ST_DRD: state_q <= ST_DWR;
				ST_DWR: state_q <= ST_CRD;
				ST_CRD: begin
					diag_q  <= diag_q + DIAG_W'(m2_q);
					state_q <= ST_CWR;
				end
				ST_CWR: begin
					if (cw_masked != '0) begin
						j_q     <= {j_q[ID_W-1:BIT_W], hi_bit(cw_masked)};
						state_q <= ST_WRD;
					end else if (j_q[ID_W-1:BIT_W] == '0) begin
						state_q <= ST_FIN;
					end else begin
						scan_q  <= j_q[ID_W-1:BIT_W] - PEND_IDX_W'(1);
						state_q <= ST_SCRD;
					end
				end
				ST_SCRD: state_q <= ST_SCHK;
				ST_SCHK: begin
					if (pend_rd != '0) begin
						j_q     <= {scan_q, hi_bit(pend_rd)};
						state_q <= ST_WRD;
					end else if (scan_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						scan_q  <= scan_q - PEND_IDX_W'(1);
						state_q <= ST_SCRD;
					end
				end
				ST_FIN: begin
					fi_q <= fi_full[F_W-1:0];
					if (recip_rsp.done) begin
						kind_q  <= K_DIAG;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						row_q     <= row_sel;
						col_q     <= col_sel;
						contr_q   <= sat32(val_sel);
						inb_q     <= sat32((W_W + 1)'($signed(fi_q)));
						err_out_q <= ERR_OK;
						last_q    <= (kind_nx == K_NONE);
						kind_q    <= kind_nx;
						if (kind_nx == K_NONE) state_q <= ST_IDLE;
					end
				end
				ST_ERR: begin
					if (out_free) begin
						row_q     <= '0;
						col_q     <= '0;
						contr_q   <= '0;
						inb_q     <= '0;
						err_out_q <= err_q;
						last_q    <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = valid_q;
	assign row_id       = row_q;
	assign col_id       = col_q;
	assign contribution = contr_q;
	assign inbreeding   = inb_q;
	assign error_code   = err_out_q;
	assign last         = last_q;

	`PIR_ASSERT_NOW(a_err_is_last, valid_q && (err_out_q != ERR_OK), last_q)
	`PIR_ASSERT_NOW(a_emit_after_recip, state_q == ST_EMIT, recip_rsp.done)
	`PIR_ASSERT_NOW(a_no_pop_in_clear, state_q == ST_CLEAR, !cmd_ready)
	`PIR_ASSERT_NEXT(a_walk_starts_recip, (state_q == ST_VAR) && (var_full > 0),
		!recip_rsp.done)

endmodule

// File: rtl/pedigree_inverse_relationship.sv
// pedigree inverse-relationship generator
// s_axis takes one animal per word in numbering order; the animal's own number is
// implicit (previous count plus one, or 1 when the restart flag is set).
// m_axis returns the inverse contributions of that animal, 1 to 9 words, tlast on
// the final one; an animal that fails a check gives a single word with the error
// code in tuser and zero data, and is not stored.
// after the checks, each ancestor visited passes through the walk states (read,
// multiply, parent updates, accumulate), and the next pending ancestor is found by
// scanning the bitmap one word of 64 animal numbers at a time; the reciprocal of
// the mendelian variance runs alongside, and the first word waits for it to finish.
// throughput: one animal at a time; a two-word queue behind the input stage keeps
// s_axis accepting while the current animal is worked on.
// after reset the pending-ancestor bitmap, all 1024 words, is cleared before the
// first animal is taken from the queue; up to three words are accepted meanwhile.
// a stalled m_axis holds its word and stops the engine before the next word; the
// input side keeps filling the queue until it is full.
module pedigree_inverse_relationship (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // sire_id, dam_id
	input  logic [0:0]  s_axis_tuser,  // start_pedigree
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // row_id, col_id, contribution, inbreeding
	output logic [1:0]  m_axis_tuser,  // error_code
	output logic        m_axis_tlast
);
	import pir_pkg::*;

	cmd_t       front_cmd, queue_cmd;
	logic       front_valid, front_ready, queue_valid, queue_ready;
	recip_req_t recip_req;
	recip_rsp_t recip_rsp;
	logic [ID_W-1:0] row_id, col_id;
	logic [31:0]     contribution, inbreeding;
	err_t            error_code;

	pir_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.sire_id        (s_axis_tdata[15:0]),
		.dam_id         (s_axis_tdata[31:16]),
		.start_pedigree (s_axis_tuser[0]),
		.cmd_valid      (front_valid),
		.cmd_ready      (front_ready),
		.cmd            (front_cmd)
	);

	pir_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_cmd    (queue_cmd)
	);

	pir_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (recip_req),
		.rsp    (recip_rsp)
	);

	pir_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (queue_valid),
		.cmd_ready    (queue_ready),
		.cmd          (queue_cmd),
		.recip_req    (recip_req),
		.recip_rsp    (recip_rsp),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.row_id       (row_id),
		.col_id       (col_id),
		.contribution (contribution),
		.inbreeding   (inbreeding),
		.error_code   (error_code),
		.last         (m_axis_tlast)
	);

	assign m_axis_tdata = {inbreeding, contribution, col_id, row_id};
	assign m_axis_tuser = error_code;

endmodule
